// ===== sv/dfwf_pkg.sv =====
package dfwf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int TAP_W       = 16;
    localparam int TAP_N       = 7;
    localparam int TAP_CENTER  = 3;
    localparam int IDX_W       = 4;
    localparam int DIM_W       = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int PROD_W      = SAMPLE_W + TAP_W;
    localparam int ACC_W       = PROD_W + 3;
    localparam int ROUND_SHIFT = 13;
    localparam int ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);

    localparam int CONTEXT_DEF = 3;
    localparam int DIM_MAX_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DIM  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP0 = 3'd1;

    localparam logic [DIM_W-1:0] DIM_RESET = 5'd13;

    localparam logic signed [TAP_W-1:0] TAP_RESET [TAP_N] = '{
        16'sd0, -16'sd6134, -16'sd3067, 16'sd0, 16'sd3067, 16'sd6134, 16'sd0
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       end_of_utterance;
    } frame_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] delta;
        logic [IDX_W-1:0]           elem_index;
        logic                       last_of_frame;
        logic                       last_of_run;
        logic                       last_of_utterance;
    } result_beat_t;

    typedef struct packed {
        logic clr;
        logic mul_en;
    } mac_ctl_t;

endpackage

// ===== sv/dfwf_mac.sv =====
module dfwf_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dfwf_pkg::mac_ctl_t                    ctl,
    input  logic signed [dfwf_pkg::SAMPLE_W-1:0]  a,
    input  logic signed [dfwf_pkg::TAP_W-1:0]     b,
    output logic signed [dfwf_pkg::SAMPLE_W-1:0]  y
);
    import dfwf_pkg::*;

    localparam int SH_W = ACC_W + 1 - ROUND_SHIFT;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     pv_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W:0]    biased;
    logic signed [SH_W-1:0]   shifted;
    logic                     ovf_pos;
    logic                     ovf_neg;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= a * b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            pv_reg <= ctl.mul_en;
            if (ctl.clr)
            begin
                acc_reg <= '0;
            end
            else if (pv_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // round half up, then saturate to Q1.15
    always_comb
    begin
        biased  = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(ROUND_BIAS);
        shifted = biased[ACC_W:ROUND_SHIFT];
        ovf_pos = !shifted[SH_W-1] && (|shifted[SH_W-2:SAMPLE_W-1]);
        ovf_neg = shifted[SH_W-1] && !(&shifted[SH_W-2:SAMPLE_W-1]);
        if (ovf_pos)
        begin
            y = {1'b0, {(SAMPLE_W - 1){1'b1}}};
        end
        else if (ovf_neg)
        begin
            y = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        end
        else
        begin
            y = shifted[SAMPLE_W-1:0];
        end
    end

endmodule

// ===== sv/delta_feature_window_filter.sv =====
// Delta (regression window) filter over a stream of feature frames.
// frame channel: one feature element per beat, dim_in_use elements per frame;
//   end_of_utterance on the last element of the final frame flushes the tail.
// result channel: element d of frame t leaves once element d of frame t+CONTEXT
//   has arrived; a flush gives the last CONTEXT frames (fewer if short) in one
//   burst, with frame indices clamped to the utterance.
// cfg channel: index 0 = dim_in_use, 1..7 = tap_0..tap_6 (Q3.13); always ready,
//   write only while the block is idle.
// Each result walks 2*CONTEXT+1 taps through one history RAM read port and one
//   shared 16x16 multiply-accumulate. frame_ready is low while results of the
//   current beat are being made; a beat with no result leaves frame_ready high.
// A full result register sits on the output: when the receiver stalls, the
//   sequencer holds its finished sum until the register drains.
// Reset clears the counters, the ring pointer and restores the register reset
//   values; the history RAM is not cleared and needs no sweep.
module delta_feature_window_filter #(
    parameter int CONTEXT = dfwf_pkg::CONTEXT_DEF,
    parameter int DIM_MAX = dfwf_pkg::DIM_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                frame_valid,
    output logic                                frame_ready,
    input  dfwf_pkg::frame_beat_t               frame_beat,
    output logic                                result_valid,
    input  logic                                result_ready,
    output dfwf_pkg::result_beat_t              result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dfwf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dfwf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dfwf_pkg::*;

    localparam int WIN    = 2 * CONTEXT + 1;
    localparam int SLOT_W = $clog2(WIN);
    localparam int JW     = $clog2(CONTEXT + 1);
    localparam int SW     = $clog2(WIN + 3);
    localparam int DEPTH  = WIN * DIM_MAX;
    localparam int AW     = $clog2(DEPTH);
    localparam int AGE_W  = SLOT_W + 2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                 state_reg;
    logic [SW-1:0]              step_reg;
    logic                       rd_v_reg;
    logic [2:0]                 tsel_reg;
    logic [SLOT_W-1:0]          frame_cnt_reg;
    logic [IDX_W-1:0]           elem_cnt_reg;
    logic [SLOT_W-1:0]          head_reg;
    logic [SLOT_W-1:0]          job_n_reg;
    logic [SLOT_W-1:0]          job_head_reg;
    logic [JW-1:0]              job_j0_reg;
    logic [JW-1:0]              cur_j_reg;
    logic [IDX_W-1:0]           cur_e_reg;
    logic                       single_reg;
    logic                       flush_reg;
    logic                       result_valid_reg;
    result_beat_t               result_reg;
    logic [DIM_W-1:0]           dim_reg;
    logic signed [TAP_W-1:0]    tap_reg [TAP_N];

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    logic [IDX_W-1:0]           dim_m1;
    logic                       accept;
    logic                       closes;
    logic                       eou;
    logic                       have_first;
    logic [JW-1:0]              j0;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;
    logic                       issue;
    logic [2:0]                 tsel;
    logic signed [AGE_W-1:0]    age_raw;
    logic [SLOT_W-1:0]          age;
    logic [SLOT_W-1:0]          slot;
    logic                       end_f;
    logic                       end_all;
    logic                       load;
    mac_ctl_t                   mac_ctl;
    logic signed [SAMPLE_W-1:0] mac_y;
    result_beat_t               result_next;

    assign frame_ready  = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign accept       = frame_valid && frame_ready;

    always_comb
    begin
        if (dim_reg == '0)
        begin
            dim_m1 = '0;
        end
        else if (dim_reg > DIM_W'(DIM_MAX))
        begin
            dim_m1 = IDX_W'(DIM_MAX - 1);
        end
        else
        begin
            dim_m1 = IDX_W'(dim_reg - 1'b1);
        end
    end

    assign closes     = (elem_cnt_reg >= dim_m1);
    assign eou        = closes && frame_beat.end_of_utterance;
    assign have_first = (frame_cnt_reg >= SLOT_W'(CONTEXT));
    assign j0         = (frame_cnt_reg < SLOT_W'(CONTEXT - 1)) ? JW'(frame_cnt_reg)
                                                               : JW'(CONTEXT - 1);
    assign wr_addr    = AW'(head_reg) * AW'(DIM_MAX) + AW'(elem_cnt_reg);

    // tap walk: age of the frame read for tap step k is j + CONTEXT - k
    assign issue = (state_reg == ST_MAC) && (step_reg < SW'(WIN));
    assign tsel  = 3'(step_reg) + 3'(TAP_CENTER - CONTEXT);

    always_comb
    begin
        age_raw = AGE_W'(cur_j_reg) + AGE_W'(CONTEXT) - AGE_W'(step_reg);
        if (age_raw < 0)
        begin
            age = '0;
        end
        else if (age_raw > $signed({2'b00, job_n_reg}))
        begin
            age = job_n_reg;
        end
        else
        begin
            age = age_raw[SLOT_W-1:0];
        end
        if (job_head_reg >= age)
        begin
            slot = job_head_reg - age;
        end
        else
        begin
            slot = SLOT_W'((SLOT_W + 1)'(job_head_reg) + (SLOT_W + 1)'(WIN)
                           - (SLOT_W + 1)'(age));
        end
        rd_addr = AW'(slot) * AW'(DIM_MAX) + AW'(cur_e_reg);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[wr_addr] <= frame_beat.sample;
        end
        rd_data_reg <= mem[rd_addr];
        tsel_reg    <= tsel;
    end

    assign mac_ctl.clr    = (state_reg == ST_MAC) && (step_reg == '0);
    assign mac_ctl.mul_en = rd_v_reg;

    dfwf_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (rd_data_reg),
        .b     (tap_reg[tsel_reg]),
        .y     (mac_y)
    );

    assign end_f   = (cur_e_reg == dim_m1);
    assign end_all = !single_reg && end_f && (cur_j_reg == '0);
    assign load    = (state_reg == ST_EMIT) && (!result_valid_reg || result_ready);

    always_comb
    begin
        result_next.delta             = mac_y;
        result_next.elem_index        = cur_e_reg;
        result_next.last_of_frame     = end_f;
        result_next.last_of_run       = single_reg ? !flush_reg : end_all;
        result_next.last_of_utterance = end_all;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            rd_v_reg         <= 1'b0;
            frame_cnt_reg    <= '0;
            elem_cnt_reg     <= '0;
            head_reg         <= '0;
            job_n_reg        <= '0;
            job_head_reg     <= '0;
            job_j0_reg       <= '0;
            cur_j_reg        <= '0;
            cur_e_reg        <= '0;
            single_reg       <= 1'b0;
            flush_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
            dim_reg          <= DIM_RESET;
            tap_reg          <= TAP_RESET;
        end
        else
        begin
            rd_v_reg <= issue;

            if (cfg_valid)
            begin
                if (cfg_index == REG_DIM)
                begin
                    dim_reg <= cfg_data[DIM_W-1:0];
                end
                else
                begin
                    tap_reg[cfg_index - REG_TAP0] <= cfg_data;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        job_n_reg    <= frame_cnt_reg;
                        job_head_reg <= head_reg;
                        job_j0_reg   <= j0;
                        flush_reg    <= eou;
                        step_reg     <= '0;
                        if (have_first)
                        begin
                            cur_j_reg  <= JW'(CONTEXT);
                            cur_e_reg  <= elem_cnt_reg;
                            single_reg <= 1'b1;
                            state_reg  <= ST_MAC;
                        end
                        else if (eou)
                        begin
                            cur_j_reg  <= j0;
                            cur_e_reg  <= '0;
                            single_reg <= 1'b0;
                            state_reg  <= ST_MAC;
                        end
                        if (eou)
                        begin
                            frame_cnt_reg <= '0;
                            elem_cnt_reg  <= '0;
                            head_reg      <= '0;
                        end
                        else if (closes)
                        begin
                            if (frame_cnt_reg != SLOT_W'(WIN - 1))
                            begin
                                frame_cnt_reg <= frame_cnt_reg + 1'b1;
                            end
                            elem_cnt_reg <= '0;
                            head_reg     <= (head_reg == SLOT_W'(WIN - 1)) ? '0
                                                                           : head_reg + 1'b1;
                        end
                        else
                        begin
                            elem_cnt_reg <= elem_cnt_reg + 1'b1;
                        end
                    end
                end
                ST_MAC:
                begin
                    if (step_reg == SW'(WIN + 2))
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (load)
                    begin
                        step_reg <= '0;
                        if (single_reg)
                        begin
                            if (flush_reg)
                            begin
                                cur_j_reg  <= job_j0_reg;
                                cur_e_reg  <= '0;
                                single_reg <= 1'b0;
                                state_reg  <= ST_MAC;
                            end
                            else
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                        else if (end_all)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (end_f)
                        begin
                            cur_j_reg <= cur_j_reg - 1'b1;
                            cur_e_reg <= '0;
                            state_reg <= ST_MAC;
                        end
                        else
                        begin
                            cur_e_reg <= cur_e_reg + 1'b1;
                            state_reg <= ST_MAC;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result beat raised outside the emit step");

    a_frame_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        frame_cnt_reg <= SLOT_W'(WIN - 1))
        else $error("frame count past its cap");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < SLOT_W'(WIN))
        else $error("ring pointer out of range");

    a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
        elem_cnt_reg <= IDX_W'(DIM_MAX - 1))
        else $error("element count beyond history row");

    a_job_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (have_first || eou) |=> (state_reg == ST_MAC))
        else $error("beat with results did not start the tap walk");
`endif

endmodule
